/* rtl/core/fdec_pkg.sv */
package fdec_pkg;

  localparam int INT_BITS     = 32;
  localparam int FRAC_FIELD_W = 32;
  localparam int DEC_W        = 4;
  localparam int CHAR_W       = 8;

  localparam int FRAC_BITS    = 32;
  localparam int MAX_DECIMALS = 8;

  localparam int INT_DIGITS   = 10;
  localparam int FRAC_CELLS   = MAX_DECIMALS + 1;
  localparam int FRAC_IDX_W   = $clog2(FRAC_CELLS);
  localparam int INT_IDX_W    = $clog2(INT_DIGITS);
  localparam int BIT_CNT_W    = $clog2(INT_BITS);

  typedef logic [3:0] bcd_t;

  typedef struct packed {
    logic clear;
    logic frac_shift;
    logic round;
    logic conv_shift;
  } cell_ctrl_t;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

  function automatic logic [CHAR_W-1:0] digit_char(bcd_t d);
    return CHAR_ZERO | {{(CHAR_W - 4){1'b0}}, d};
  endfunction

endpackage

/* rtl/core/fdec_in_if.sv */
interface fdec_in_if;
  logic                                valid;
  logic                                ready;
  logic                                negative;
  logic [fdec_pkg::INT_BITS-1:0]       int_part;
  logic [fdec_pkg::FRAC_FIELD_W-1:0]   frac_part;
  logic [fdec_pkg::DEC_W-1:0]          decimals;

  modport source (output valid, negative, int_part, frac_part, decimals, input ready);
  modport sink (input valid, negative, int_part, frac_part, decimals, output ready);
endinterface

/* rtl/core/fdec_out_if.sv */
interface fdec_out_if;
  logic                          valid;
  logic                          ready;
  logic [fdec_pkg::CHAR_W-1:0]   char_code;
  logic                          last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink (input valid, char_code, last_char, output ready);
endinterface

/* rtl/core/fixed_to_decimal_ascii_unit.sv */
// Converts one signed fixed-point number (sign, 32-bit integer magnitude, 32-bit binary
// fraction) into its decimal text, one ASCII character per output beat, with last_char
// set on the final beat. The text is an optional minus, the integer without leading
// zeros, then a comma and the rounded, zero-padded fraction digits when decimals is
// nonzero; decimals above eight count as eight. One number is handled at a time: after
// the input beat the block generates decimals + 1 fraction digits, rounds, shifts the
// integer through the binary-to-BCD cell row one bit per cycle and finds the leading
// integer digit, then sends one character per cycle while the output is ready. The
// input is ready again once the last character has been taken.
module fixed_to_decimal_ascii_unit (
  input  logic         clk,
  input  logic         rst,
  fdec_in_if.sink      num,
  fdec_out_if.source   text
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FRAC,
    S_ROUND,
    S_CONV,
    S_SKIP,
    S_SIGN,
    S_INT,
    S_COMMA,
    S_FDIG
  } state_t;

  state_t                                state;
  logic [fdec_pkg::FRAC_BITS-1:0]        frac;
  logic [fdec_pkg::INT_BITS-1:0]         ip;
  logic [fdec_pkg::FRAC_IDX_W-1:0]       nd;
  logic [fdec_pkg::FRAC_IDX_W-1:0]       step_cnt;
  logic [fdec_pkg::FRAC_IDX_W-1:0]       frac_idx;
  logic [fdec_pkg::INT_IDX_W-1:0]        int_idx;
  logic [fdec_pkg::BIT_CNT_W-1:0]        bit_cnt;
  logic                                  show_minus;

  logic                                  accept;
  logic [fdec_pkg::FRAC_BITS-1:0]        frac_in;
  logic [fdec_pkg::FRAC_IDX_W-1:0]       nd_load;
  logic [fdec_pkg::FRAC_BITS+3:0]        frac_x10;
  fdec_pkg::bcd_t                        frac_digit;
  logic                                  round_carry;
  fdec_pkg::cell_ctrl_t                  ctrl;

  fdec_pkg::bcd_t                        fd [fdec_pkg::FRAC_CELLS];
  logic [fdec_pkg::FRAC_CELLS-1:0]       fco;
  fdec_pkg::bcd_t                        id [fdec_pkg::INT_DIGITS];
  logic [fdec_pkg::INT_DIGITS-1:0]       ibo;

  assign accept  = num.valid && num.ready;
  assign frac_in = num.frac_part[fdec_pkg::FRAC_BITS-1:0];
  assign nd_load = (num.decimals > fdec_pkg::DEC_W'(fdec_pkg::MAX_DECIMALS)) ?
                   fdec_pkg::FRAC_IDX_W'(fdec_pkg::MAX_DECIMALS) :
                   num.decimals[fdec_pkg::FRAC_IDX_W-1:0];

  assign frac_x10   = ({4'b0000, frac} << 3) + ({4'b0000, frac} << 1);
  assign frac_digit = frac_x10[fdec_pkg::FRAC_BITS+3:fdec_pkg::FRAC_BITS];
  assign round_carry = fco[nd];

  assign ctrl.clear      = accept;
  assign ctrl.frac_shift = (state == S_FRAC);
  assign ctrl.round      = (state == S_ROUND);
  assign ctrl.conv_shift = (state == S_CONV);

  for (genvar k = 0; k < fdec_pkg::FRAC_CELLS; k++) begin : g_frac
    if (k == 0) begin : g_first
      fdec_frac_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .digit_in (frac_digit),
        .add      (4'd5),
        .digit    (fd[k]),
        .carry    (fco[k])
      );
    end else begin : g_rest
      fdec_frac_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .digit_in (fd[k-1]),
        .add      ({3'b000, fco[k-1]}),
        .digit    (fd[k]),
        .carry    (fco[k])
      );
    end
  end

  for (genvar k = 0; k < fdec_pkg::INT_DIGITS; k++) begin : g_int
    if (k == 0) begin : g_first
      fdec_dd_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .bit_in  (ip[fdec_pkg::INT_BITS-1]),
        .digit   (id[k]),
        .bit_out (ibo[k])
      );
    end else begin : g_rest
      fdec_dd_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .bit_in  (ibo[k-1]),
        .digit   (id[k]),
        .bit_out (ibo[k])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            frac       <= frac_in;
            ip         <= num.int_part;
            nd         <= nd_load;
            step_cnt   <= nd_load;
            show_minus <= num.negative && ((num.int_part != '0) || (frac_in != '0));
            state      <= S_FRAC;
          end
        end
        S_FRAC: begin
          frac <= frac_x10[fdec_pkg::FRAC_BITS-1:0];
          if (step_cnt == '0) begin
            state <= S_ROUND;
          end else begin
            step_cnt <= step_cnt - fdec_pkg::FRAC_IDX_W'(1);
          end
        end
        S_ROUND: begin
          ip      <= ip + fdec_pkg::INT_BITS'(round_carry);
          bit_cnt <= '0;
          state   <= S_CONV;
        end
        S_CONV: begin
          ip      <= ip << 1;
          bit_cnt <= bit_cnt + fdec_pkg::BIT_CNT_W'(1);
          if (bit_cnt == fdec_pkg::BIT_CNT_W'(fdec_pkg::INT_BITS - 1)) begin
            int_idx <= fdec_pkg::INT_IDX_W'(fdec_pkg::INT_DIGITS - 1);
            state   <= S_SKIP;
          end
        end
        S_SKIP: begin
          if ((int_idx != '0) && (id[int_idx] == '0)) begin
            int_idx <= int_idx - fdec_pkg::INT_IDX_W'(1);
          end else begin
            state <= show_minus ? S_SIGN : S_INT;
          end
        end
        S_SIGN: begin
          if (text.ready) begin
            state <= S_INT;
          end
        end
        S_INT: begin
          if (text.ready) begin
            if (int_idx != '0) begin
              int_idx <= int_idx - fdec_pkg::INT_IDX_W'(1);
            end else if (nd != '0) begin
              state <= S_COMMA;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_COMMA: begin
          if (text.ready) begin
            frac_idx <= nd;
            state    <= S_FDIG;
          end
        end
        S_FDIG: begin
          if (text.ready) begin
            if (frac_idx == fdec_pkg::FRAC_IDX_W'(1)) begin
              state <= S_IDLE;
            end else begin
              frac_idx <= frac_idx - fdec_pkg::FRAC_IDX_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign num.ready  = (state == S_IDLE);
  assign text.valid = (state == S_SIGN) || (state == S_INT) ||
                      (state == S_COMMA) || (state == S_FDIG);

  always_comb begin
    case (state)
      S_SIGN: begin
        text.char_code = fdec_pkg::CHAR_MINUS;
        text.last_char = 1'b0;
      end
      S_INT: begin
        text.char_code = fdec_pkg::digit_char(id[int_idx]);
        text.last_char = (int_idx == '0) && (nd == '0);
      end
      S_COMMA: begin
        text.char_code = fdec_pkg::CHAR_COMMA;
        text.last_char = 1'b0;
      end
      S_FDIG: begin
        text.char_code = fdec_pkg::digit_char(fd[frac_idx]);
        text.last_char = (frac_idx == fdec_pkg::FRAC_IDX_W'(1));
      end
      default: begin
        text.char_code = fdec_pkg::CHAR_ZERO;
        text.last_char = 1'b0;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // The input side and the output side are never active together.
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    num.ready |-> !text.valid)
    else $error("input ready while a character is offered");

  // The top BCD cell never overflows during conversion.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV) |-> !ibo[fdec_pkg::INT_DIGITS-1])
    else $error("binary-to-BCD cell row overflowed");

  // Integer digits sent are valid decimal digits.
  a_int_bcd: assert property (@(posedge clk) disable iff (rst)
    (state == S_INT) |-> (id[int_idx] <= 4'd9))
    else $error("integer digit out of range");

  // Fraction digits sent are valid decimal digits.
  a_frac_bcd: assert property (@(posedge clk) disable iff (rst)
    (state == S_FDIG) |-> (fd[frac_idx] <= 4'd9))
    else $error("fraction digit out of range");

  // The final beat of a number frees the input.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (text.valid && text.ready && text.last_char) |=> num.ready)
    else $error("block not idle after the final beat");
`endif

endmodule

/* rtl/core/fdec_frac_cell.sv */
module fdec_frac_cell (
  input  logic                 clk,
  input  fdec_pkg::cell_ctrl_t ctrl,
  input  fdec_pkg::bcd_t       digit_in,
  input  fdec_pkg::bcd_t       add,
  output fdec_pkg::bcd_t       digit,
  output logic                 carry
);

  logic [4:0] sum;

  assign sum   = {1'b0, digit} + {1'b0, add};
  assign carry = (sum >= 5'd10);

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.frac_shift) begin
      digit <= digit_in;
    end else if (ctrl.round) begin
      digit <= carry ? 4'(sum - 5'd10) : sum[3:0];
    end
  end

endmodule

/* rtl/core/fdec_dd_cell.sv */
module fdec_dd_cell (
  input  logic                 clk,
  input  fdec_pkg::cell_ctrl_t ctrl,
  input  logic                 bit_in,
  output fdec_pkg::bcd_t       digit,
  output logic                 bit_out
);

  fdec_pkg::bcd_t corr;

  // A digit of five or more is corrected before the shift so that it carries properly.
  assign corr    = (digit >= 4'd5) ? digit + 4'd3 : digit;
  assign bit_out = corr[3];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.conv_shift) begin
      digit <= {corr[2:0], bit_in};
    end
  end

endmodule

/* sim/tb_fixed_to_decimal_ascii_unit.sv */
`timescale 1ns / 100ps

module tb_fixed_to_decimal_ascii_unit;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 100;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT_ITEM = 60;

  typedef struct {
    logic                              negative;
    logic [fdec_pkg::INT_BITS-1:0]     int_part;
    logic [fdec_pkg::FRAC_FIELD_W-1:0] frac_part;
    logic [fdec_pkg::DEC_W-1:0]        decimals;
    int                                gap;
    bit                                drain;
  } num_item_t;

  typedef struct {
    logic [fdec_pkg::CHAR_W-1:0] code;
    logic                        last;
  } char_beat_t;

  logic clk;
  logic rst;

  fdec_in_if  num_if ();
  fdec_out_if text_if ();

  fixed_to_decimal_ascii_unit dut (
    .clk  (clk),
    .rst  (rst),
    .num  (num_if),
    .text (text_if)
  );

  num_item_t  pending[$];
  char_beat_t expected_text[$];
  int chars_expected = 0;
  int chars_taken = 0;
  int items_accepted = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int rx_gap = 0;
  int rx_hold = 0;
  bit hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Works out the text of one number and appends its characters to expected_text.
  function automatic int queue_text(input num_item_t it);
    logic [fdec_pkg::CHAR_W-1:0] txt[20];
    logic [fdec_pkg::CHAR_W-1:0] digs[10];
    logic [63:0]       fmask;
    logic [63:0]       fr;
    logic [63:0]       scale;
    logic [63:0]       frac_dec;
    logic [63:0]       div;
    logic [31:0]       ip;
    int                nd;
    int                n;
    int                ilen;
    fmask = (64'd1 << fdec_pkg::FRAC_BITS) - 64'd1;
    fr = {32'd0, it.frac_part} & fmask;
    ip = it.int_part;
    nd = (it.decimals > fdec_pkg::MAX_DECIMALS) ? fdec_pkg::MAX_DECIMALS : int'(it.decimals);
    n = 0;
    ilen = 0;
    scale = 64'd10;
    for (int k = 0; k < nd; k++) scale = scale * 64'd10;
    frac_dec = (scale * fr) >> fdec_pkg::FRAC_BITS;
    if (frac_dec % 10 >= 5) frac_dec = frac_dec + 64'd10;
    if (frac_dec > scale - 64'd1) begin
      ip = ip + 32'd1;
      frac_dec = 64'd0;
    end
    frac_dec = frac_dec / 64'd10;
    if (it.negative && (it.int_part != 0 || fr != 0)) begin
      txt[n] = fdec_pkg::CHAR_MINUS;
      n++;
    end
    do begin
      digs[ilen] = fdec_pkg::CHAR_ZERO + 8'(ip % 10);
      ilen++;
      ip = ip / 10;
    end while (ip != 0);
    while (ilen > 0) begin
      ilen--;
      txt[n] = digs[ilen];
      n++;
    end
    if (nd != 0) begin
      txt[n] = fdec_pkg::CHAR_COMMA;
      n++;
      div = 64'd1;
      for (int k = 1; k < nd; k++) div = div * 64'd10;
      for (int k = 0; k < nd; k++) begin
        txt[n] = fdec_pkg::CHAR_ZERO + 8'((frac_dec / div) % 10);
        n++;
        div = (div >= 64'd10) ? div / 64'd10 : 64'd1;
      end
    end
    for (int i = 0; i < n; i++) begin
      expected_text.push_back('{code: txt[i], last: (i == n - 1)});
    end
    return n;
  endfunction

  task automatic add_number(input logic neg, input logic [31:0] ip, input logic [31:0] fr,
                            input logic [3:0] dec);
    pending.push_back('{negative: neg, int_part: ip, frac_part: fr, decimals: dec,
                        gap: 0, drain: 1'b0});
  endtask

  function automatic num_item_t rand_number(input int idx);
    num_item_t it;
    int pick;
    it.negative = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    case (pick)
      0: it.int_part = 32'd0;
      1: it.int_part = 32'($urandom_range(0, 99));
      2: it.int_part = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
      3: it.int_part = 32'd999_999_999 + 32'($urandom_range(0, 1));
      4: it.int_part = 32'd1 << $urandom_range(0, 31);
      default: it.int_part = $urandom();
    endcase
    pick = $urandom_range(0, 9);
    case (pick)
      0: it.frac_part = 32'd0;
      1: it.frac_part = 32'h8000_0000;
      2: it.frac_part = 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
      3: it.frac_part = 32'($urandom_range(0, 255));
      default: it.frac_part = $urandom();
    endcase
    if ($urandom_range(0, 99) < 85) it.decimals = 4'($urandom_range(0, 8));
    else it.decimals = 4'($urandom_range(9, 15));
    it.gap = ((idx / 20) % 4 == 0) ? 0 : idle_len();
    it.drain = (idx == 0 || idx == 100);
    return it;
  endfunction

  always @(posedge clk) begin
    num_item_t seen;
    num_item_t nxt;
    logic      offer;
    int        owed;
    if (rst) begin
      num_if.valid <= 1'b0;
    end else begin
      offer = num_if.valid;
      owed = chars_expected;
      if (num_if.valid && num_if.ready) begin
        seen.negative = num_if.negative;
        seen.int_part = num_if.int_part;
        seen.frac_part = num_if.frac_part;
        seen.decimals = num_if.decimals;
        owed = owed + queue_text(seen);
        chars_expected <= owed;
        items_accepted <= items_accepted + 1;
        offer = 1'b0;
      end
      if (!offer && pending.size() != 0) begin
        if (pending[0].gap != 0) begin
          pending[0].gap = pending[0].gap - 1;
        end else if (!pending[0].drain || owed == chars_taken) begin
          nxt = pending.pop_front();
          num_if.negative <= nxt.negative;
          num_if.int_part <= nxt.int_part;
          num_if.frac_part <= nxt.frac_part;
          num_if.decimals <= nxt.decimals;
          offer = 1'b1;
        end
      end
      num_if.valid <= offer;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rx_hold <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && items_accepted == HOLD_AT_ITEM) begin
      rx_hold <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end
  end

  always @(posedge clk) begin
    char_beat_t want;
    if (rst) begin
      text_if.ready <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (text_if.valid && text_if.ready) begin
        chars_taken <= chars_taken + 1;
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("beat with nothing expected: char 0x%02h last %0b",
                                    text_if.char_code, text_if.last_char));
        end else begin
          want = expected_text.pop_front();
          if (text_if.char_code !== want.code) begin
            report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
                                      text_if.char_code, want.code));
          end
          if (text_if.last_char !== want.last) begin
            report_mismatch($sformatf("last_char %0b, expected %0b",
                                      text_if.last_char, want.last));
          end
        end
      end
      if (rx_hold != 0) begin
        text_if.ready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap <= rx_gap - 1;
        text_if.ready <= 1'b0;
      end else begin
        text_if.ready <= 1'b1;
        rx_gap <= ((cycle_cnt % 1024) < 256) ? 0 : idle_len();
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_fixed_to_decimal_ascii_unit: errors");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;

    add_number(1'b0, 32'd0, 32'd0, 4'd0);
    add_number(1'b1, 32'd0, 32'd0, 4'd3);
    add_number(1'b1, 32'd0, 32'd1, 4'd2);
    add_number(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd8);
    add_number(1'b0, 32'hFFFF_FFFF, 32'h8000_0000, 4'd0);
    add_number(1'b0, 32'hFFFF_FFFF, 32'd0, 4'd2);
    add_number(1'b0, 32'd0, 32'h8000_0000, 4'd0);
    add_number(1'b0, 32'd0, 32'h8000_0000, 4'd1);
    add_number(1'b1, 32'd9, 32'hFFFF_FFFF, 4'd0);
    add_number(1'b0, 32'd99, 32'hFF00_0000, 4'd1);
    add_number(1'b0, 32'd1_234_567_890, 32'h4000_0000, 4'd4);
    add_number(1'b1, 32'd42, 32'hAAAA_AAAA, 4'd9);
    add_number(1'b0, 32'd7, 32'h5555_5555, 4'd15);
    add_number(1'b0, 32'd999_999_999, 32'hFFFF_FFFF, 4'd8);
    add_number(1'b1, 32'd1, 32'd0, 4'd8);
    add_number(1'b0, 32'd10, 32'h0000_0001, 4'd8);
    add_number(1'b1, 32'h8000_0000, 32'h1999_999A, 4'd1);
    add_number(1'b0, 32'd5, 32'h0CCC_CCCD, 4'd1);
    add_number(1'b1, 32'd123, 32'h0000_0000, 4'd12);
    add_number(1'b0, 32'd0, 32'h0000_2AF3, 4'd5);
    for (int i = 0; i < 130; i++) pending.push_back(rand_number(i));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (pending.size() != 0 || num_if.valid || chars_taken != chars_expected) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_text.size() != 0) begin
      report_mismatch($sformatf("%0d characters never arrived", expected_text.size()));
    end
    if (err_cnt == 0) begin
      $display("tb_fixed_to_decimal_ascii_unit: clean");
    end else begin
      $display("tb_fixed_to_decimal_ascii_unit: errors");
    end
    $finish;
  end

endmodule
